// ===== hw/rtl/jsu_pkg.sv =====
// jsu_pkg: types, constants and helper functions of the json string unescape unit
// used by jsu_front, jsu_queue, jsu_back and json_string_unescape_unit
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int MAX_FRAME_BYTES = 65536;
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int EXT_W = (POS_W > 16) ? POS_W + 1 : 17;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef enum logic [3:0] {
    PH_SKIP,
    PH_BODY,
    PH_ESC,
    PH_HEX1,
    PH_PAIR_BS,
    PH_PAIR_U,
    PH_HEX2,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_frame;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  result_kind;
    logic [15:0] consumed_count;
    logic        last_of_run;
  } out_word_t;

  // all results caused by one text byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n_bytes;
    logic            has_tail;
    kind_t           tail_kind;
    logic [15:0]     consumed_count;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n_bytes;
  } utf8_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t e;
    e.bytes = '0;
    if (cp <= 21'h7F) begin
      e.n_bytes = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.n_bytes = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.n_bytes = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.n_bytes = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jsu_front.sv =====
// jsu_front: takes text words, tracks frame position and parse phase,
// turns each word into a run of results; depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               text_valid,
  output logic                    text_stall,
  input  wire jsu_pkg::in_word_t  text,
  input  wire logic               cfg_write_en,
  input  wire logic [15:0]        cfg_write_data,
  input  wire jsu_pkg::queue_status_t qstat,
  output logic                    push,
  output jsu_pkg::run_t           run
);

  jsu_pkg::phase_t                phase, phase_next;
  logic [15:0]                    acc, acc_next;
  logic [9:0]                     high_sur, high_sur_next;
  logic [1:0]                     digit_count, digit_count_next;
  logic [jsu_pkg::POS_W-1:0]      position, position_next;
  logic [15:0]                    start_offset;

  logic                           accept;
  logic                           err;
  jsu_pkg::hex_t                  hex;
  logic [15:0]                    acc_new;
  jsu_pkg::utf8_t                 enc;
  logic [jsu_pkg::EXT_W-1:0]      pos_ext;
  logic [jsu_pkg::EXT_W-1:0]      cnt_ext;
  logic                           overlong;

  assign text_stall = qstat.full;
  assign accept     = text_valid && !text_stall;
  assign hex        = jsu_pkg::hex_value(text.text_byte);
  assign acc_new    = {acc[11:0], hex.value};
  assign pos_ext    = jsu_pkg::EXT_W'(position);
  assign cnt_ext    = pos_ext + jsu_pkg::EXT_W'(1);
  assign overlong   = position >= jsu_pkg::POS_W'(jsu_pkg::MAX_FRAME_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= jsu_pkg::PH_SKIP;
      acc          <= '0;
      high_sur     <= '0;
      digit_count  <= '0;
      position     <= '0;
      start_offset <= '0;
    end else begin
      phase       <= phase_next;
      acc         <= acc_next;
      high_sur    <= high_sur_next;
      digit_count <= digit_count_next;
      position    <= position_next;
      if (cfg_write_en) begin
        start_offset <= cfg_write_data;
      end
    end
  end

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    high_sur_next    = high_sur;
    digit_count_next = digit_count;
    position_next    = position;
    run              = '0;
    run.tail_kind    = jsu_pkg::KIND_BYTE;
    err              = 1'b0;
    enc              = '0;
    push             = 1'b0;
    if (accept) begin
      if (!overlong) begin
        position_next = position + jsu_pkg::POS_W'(1);
      end
      if (phase != jsu_pkg::PH_DRAIN && overlong) begin
        err = 1'b1;
      end else begin
        unique case (phase)
          jsu_pkg::PH_SKIP: begin
            if (pos_ext >= jsu_pkg::EXT_W'(start_offset)) begin
              if (text.text_byte == jsu_pkg::CH_QUOTE) begin
                phase_next = jsu_pkg::PH_BODY;
              end else begin
                err = 1'b1;
              end
            end
          end
          jsu_pkg::PH_BODY: begin
            if (text.text_byte == jsu_pkg::CH_BACKSLASH) begin
              phase_next = jsu_pkg::PH_ESC;
            end else if (text.text_byte == jsu_pkg::CH_QUOTE) begin
              run.has_tail  = 1'b1;
              run.tail_kind = jsu_pkg::KIND_DONE;
              run.consumed_count = (cnt_ext > jsu_pkg::EXT_W'(16'hFFFF)) ?
                                   16'hFFFF : cnt_ext[15:0];
              phase_next = jsu_pkg::PH_DRAIN;
            end else if (text.text_byte < jsu_pkg::CH_SPACE) begin
              err = 1'b1;
            end else begin
              run.bytes[0] = text.text_byte;
              run.n_bytes  = 3'd1;
            end
          end
          jsu_pkg::PH_ESC: begin
            phase_next   = jsu_pkg::PH_BODY;
            run.n_bytes  = 3'd1;
            run.bytes[0] = text.text_byte;
            unique case (text.text_byte)
              jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: begin
              end
              jsu_pkg::CH_B: run.bytes[0] = 8'h08;
              jsu_pkg::CH_F: run.bytes[0] = 8'h0C;
              jsu_pkg::CH_N: run.bytes[0] = 8'h0A;
              jsu_pkg::CH_R: run.bytes[0] = 8'h0D;
              jsu_pkg::CH_T: run.bytes[0] = 8'h09;
              jsu_pkg::CH_U: begin
                run.n_bytes      = 3'd0;
                run.bytes[0]     = 8'h00;
                phase_next       = jsu_pkg::PH_HEX1;
                acc_next         = '0;
                digit_count_next = '0;
              end
              default: begin
                run.n_bytes  = 3'd0;
                run.bytes[0] = 8'h00;
                err          = 1'b1;
              end
            endcase
          end
          jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
            if (!hex.valid) begin
              err = 1'b1;
            end else begin
              acc_next = acc_new;
              if (digit_count != 2'd3) begin
                digit_count_next = digit_count + 2'd1;
              end else begin
                digit_count_next = '0;
                if (phase == jsu_pkg::PH_HEX1) begin
                  if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                    high_sur_next = acc_new[9:0];
                    phase_next    = jsu_pkg::PH_PAIR_BS;
                  end else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
                    err = 1'b1;
                  end else begin
                    enc         = jsu_pkg::utf8_encode(21'(acc_new));
                    run.bytes   = enc.bytes;
                    run.n_bytes = enc.n_bytes;
                    phase_next  = jsu_pkg::PH_BODY;
                  end
                end else begin
                  if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                    err = 1'b1;
                  end else begin
                    enc = jsu_pkg::utf8_encode(21'h10000 +
                                               21'({high_sur, acc_new[9:0]}));
                    run.bytes   = enc.bytes;
                    run.n_bytes = enc.n_bytes;
                    phase_next  = jsu_pkg::PH_BODY;
                  end
                end
              end
            end
          end
          jsu_pkg::PH_PAIR_BS: begin
            if (text.text_byte == jsu_pkg::CH_BACKSLASH) begin
              phase_next = jsu_pkg::PH_PAIR_U;
            end else begin
              err = 1'b1;
            end
          end
          jsu_pkg::PH_PAIR_U: begin
            if (text.text_byte == jsu_pkg::CH_U) begin
              phase_next       = jsu_pkg::PH_HEX2;
              acc_next         = '0;
              digit_count_next = '0;
            end else begin
              err = 1'b1;
            end
          end
          jsu_pkg::PH_DRAIN: begin
          end
          default: begin
          end
        endcase
      end
      if (text.end_of_frame && phase_next != jsu_pkg::PH_DRAIN) begin
        err = 1'b1;
      end
      if (err) begin
        run.has_tail       = 1'b1;
        run.tail_kind      = jsu_pkg::KIND_ERR;
        run.consumed_count = '0;
        phase_next         = jsu_pkg::PH_DRAIN;
      end
      if (text.end_of_frame) begin
        phase_next       = jsu_pkg::PH_SKIP;
        position_next    = '0;
        acc_next         = '0;
        digit_count_next = '0;
        high_sur_next    = '0;
      end
      push = run.has_tail || (run.n_bytes != 3'd0);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_queue.sv =====
// jsu_queue: short flop queue of result runs between front and back
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire jsu_pkg::run_t  push_run,
  input  wire logic           pop,
  output jsu_pkg::run_t       head,
  output jsu_pkg::queue_status_t qstat
);

  jsu_pkg::run_t              entries [jsu_pkg::QUEUE_DEPTH];
  logic [jsu_pkg::QPTR_W-1:0] wr_ptr;
  logic [jsu_pkg::QPTR_W-1:0] rd_ptr;
  logic [jsu_pkg::QCNT_W-1:0] count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = count == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH);
  assign qstat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == jsu_pkg::QPTR_W'(jsu_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + jsu_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == jsu_pkg::QPTR_W'(jsu_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + jsu_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + jsu_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - jsu_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full || pop)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + jsu_pkg::QCNT_W'(1))
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_back.sv =====
// jsu_back: walks each queued run one result per cycle, while the output is not stalled, into the output register
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire jsu_pkg::run_t     head,
  input  wire jsu_pkg::queue_status_t qstat,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output jsu_pkg::out_word_t     result
);

  logic [2:0]          idx, idx_next;
  logic [2:0]          total;
  logic                load;
  logic                last;
  jsu_pkg::out_word_t  word;

  assign total = head.n_bytes + {2'b00, head.has_tail};
  assign load  = !qstat.empty && (!result_valid || !result_stall);
  assign last  = idx == total - 3'd1;
  assign pop   = load && last;

  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = last ? 3'd0 : idx + 3'd1;
    end
    word.last_of_run = last;
    if (idx < head.n_bytes) begin
      word.out_byte       = head.bytes[idx[1:0]];
      word.result_kind    = jsu_pkg::KIND_BYTE;
      word.consumed_count = '0;
    end else begin
      word.out_byte       = '0;
      word.result_kind    = head.tail_kind;
      word.consumed_count = head.consumed_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= word;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/json_string_unescape_unit.sv =====
// json_string_unescape_unit: top level of the json string unescape unit
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
//
// usage:
//   text channel (text_valid, text_stall, text) carries one frame byte per word,
//   end_of_frame on the last byte of a frame. result channel (result_valid,
//   result_stall, result) carries decoded bytes, a done word with the position
//   after the closing quote, or an error word; last_of_run marks the final
//   result caused by one text word. start_offset is written through cfg_write_en
//   / cfg_write_data, which the user must do only while the unit is idle; the unit
//   does not enforce this. The first result of a text word goes into a run queue
//   entry and then into the output register that drives the result port.
//   throughput: one text word per cycle for plain bytes while neither stall is held;
//   one text word can cause up to five results (four utf-8 bytes and an error),
//   sent one per cycle by the back end, so the output port sets the sustained
//   rate; a four-entry run queue absorbs those bursts.
//   reset clears phase, position, start_offset and the queue; no clearing pass.
//   when result_stall is held the output word holds, the queue fills and then
//   text_stall rises; no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              text_valid,
  output logic                   text_stall,
  input  wire jsu_pkg::in_word_t text,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output jsu_pkg::out_word_t     result,
  input  wire logic              cfg_write_en,
  input  wire logic [15:0]       cfg_write_data
);

  jsu_pkg::queue_status_t qstat;
  jsu_pkg::run_t          push_run;
  jsu_pkg::run_t          head;
  logic                   push;
  logic                   pop;

  jsu_front u_front (
    .clk            (clk),
    .rst            (rst),
    .text_valid     (text_valid),
    .text_stall     (text_stall),
    .text           (text),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .qstat          (qstat),
    .push           (push),
    .run            (push_run)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
